### rtl/tcrr_pkg.sv
// Package for the text cell refresh renderer: payload structs, cell and range
// records, configuration register map and command codes. No dependencies.
package tcrr_pkg;

  localparam int COLS_DEF       = 32;
  localparam int ROWS_DEF       = 16;
  localparam int FONT_BYTES_DEF = 4096;
  localparam int RANGES_DEF     = 16;
  localparam int MAX_FONT_H_DEF = 16;

  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  localparam logic [2:0] REG_FONT_W   = 3'd0;
  localparam logic [2:0] REG_FONT_H   = 3'd1;
  localparam logic [2:0] REG_X_OFFSET = 3'd2;
  localparam logic [2:0] REG_Y_OFFSET = 3'd3;
  localparam logic [2:0] REG_COLS     = 3'd4;
  localparam logic [2:0] REG_ROWS     = 3'd5;

  localparam logic [1:0] CMD_LOAD_FONT  = 2'd0;
  localparam logic [1:0] CMD_LOAD_RANGE = 2'd1;
  localparam logic [1:0] CMD_WRITE_CELL = 2'd2;
  localparam logic [1:0] CMD_REFRESH    = 2'd3;

  typedef struct packed {
    logic [1:0]  command;
    logic [4:0]  col;
    logic [3:0]  row;
    logic [20:0] glyph;
    logic [15:0] fg;
    logic [15:0] bg;
    logic        force_req;
    logic [11:0] font_address;
    logic [7:0]  font_byte;
    logic [3:0]  range_index;
    logic [15:0] range_count;
  } in_item_t;

  typedef struct packed {
    logic [10:0] pixel_x;
    logic [10:0] pixel_y;
    logic [7:0]  row_bits;
    logic [15:0] fg_color;
    logic [15:0] bg_color;
    logic        no_glyph;
    logic        last_row;
  } out_item_t;

  typedef struct packed {
    logic [20:0] code;
    logic [15:0] fg;
    logic [15:0] bg;
  } cell_t;

  typedef struct packed {
    logic [11:0] offset;
    logic [20:0] first;
    logic [15:0] count;
  } rng_t;

  typedef struct packed {
    logic [3:0] font_width;
    logic [4:0] font_height;
    logic [9:0] x_offset;
    logic [9:0] y_offset;
    logic [5:0] cols_in_use;
    logic [4:0] rows_in_use;
  } cfg_t;

  typedef struct packed {
    logic rd;
    logic wr_cur;
    logic wr_sh;
  } cell_ctl_t;

endpackage

### rtl/tcrr_cfg_regs.sv
// Configuration registers of the text cell refresh renderer behind an APB-style port.
// Depends on tcrr_pkg.
module tcrr_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tcrr_pkg::CFG_AW-1:0]   paddr,
  input  logic [tcrr_pkg::CFG_DW-1:0]   pwdata,
  output logic [tcrr_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready,
  output tcrr_pkg::cfg_t                cfg
);
  import tcrr_pkg::*;

  cfg_t       cfg_r;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[CFG_AW-1:2];
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.font_width  <= 4'd8;
      cfg_r.font_height <= 5'd16;
      cfg_r.x_offset    <= '0;
      cfg_r.y_offset    <= '0;
      cfg_r.cols_in_use <= 6'd32;
      cfg_r.rows_in_use <= 5'd16;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_FONT_W:   cfg_r.font_width  <= pwdata[3:0];
        REG_FONT_H:   cfg_r.font_height <= pwdata[4:0];
        REG_X_OFFSET: cfg_r.x_offset    <= pwdata[9:0];
        REG_Y_OFFSET: cfg_r.y_offset    <= pwdata[9:0];
        REG_COLS:     cfg_r.cols_in_use <= pwdata[5:0];
        REG_ROWS:     cfg_r.rows_in_use <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FONT_W:   prdata = CFG_DW'(cfg_r.font_width);
      REG_FONT_H:   prdata = CFG_DW'(cfg_r.font_height);
      REG_X_OFFSET: prdata = CFG_DW'(cfg_r.x_offset);
      REG_Y_OFFSET: prdata = CFG_DW'(cfg_r.y_offset);
      REG_COLS:     prdata = CFG_DW'(cfg_r.cols_in_use);
      REG_ROWS:     prdata = CFG_DW'(cfg_r.rows_in_use);
      default:      prdata = '0;
    endcase
  end

endmodule

### rtl/tcrr_cell_mem.sv
// Current and shadow cell memories with the clearing sweep that follows reset.
// Depends on tcrr_pkg.
module tcrr_cell_mem #(
  parameter int CELLS   = 512,
  parameter int CELL_AW = 9
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tcrr_pkg::cell_ctl_t  ctl,
  input  logic [CELL_AW-1:0]   addr,
  input  tcrr_pkg::cell_t      wdata,
  output tcrr_pkg::cell_t      cur_q,
  output tcrr_pkg::cell_t      sh_q,
  output logic                 busy
);
  import tcrr_pkg::*;

  localparam int CNT_W = $clog2(CELLS + 1);

  cell_t cur_mem [CELLS];
  cell_t sh_mem  [CELLS];
  cell_t cur_q_r;
  cell_t sh_q_r;
  logic  busy_r;
  logic [CNT_W-1:0]   clr_cnt_r;
  logic [CELL_AW-1:0] wa;
  cell_t              cur_wd;
  cell_t              sh_wd;

  assign busy   = busy_r;
  assign cur_q  = cur_q_r;
  assign sh_q   = sh_q_r;
  assign wa     = busy_r ? clr_cnt_r[CELL_AW-1:0] : addr;
  assign cur_wd = busy_r ? '1 : wdata;
  assign sh_wd  = busy_r ? '1 : cur_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b1;
      clr_cnt_r <= '0;
    end else if (busy_r) begin
      clr_cnt_r <= clr_cnt_r + CNT_W'(1);
      if (clr_cnt_r == CNT_W'(CELLS - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r || ctl.wr_cur) begin
      cur_mem[wa] <= cur_wd;
    end
    if (busy_r || ctl.wr_sh) begin
      sh_mem[wa] <= sh_wd;
    end
    if (ctl.rd) begin
      cur_q_r <= cur_mem[addr];
      sh_q_r  <= sh_mem[addr];
    end
  end

endmodule

### rtl/tcrr_range_mem.sv
// Codepoint range table memory; entries never loaded read as zero.
// Depends on tcrr_pkg.
module tcrr_range_mem #(
  parameter int RANGES = 16,
  parameter int RNG_AW = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               we,
  input  logic [RNG_AW-1:0]  waddr,
  input  tcrr_pkg::rng_t     wdata,
  input  logic               re,
  input  logic [RNG_AW-1:0]  raddr,
  output tcrr_pkg::rng_t     q
);
  import tcrr_pkg::*;

  rng_t              mem [RANGES];
  logic [RANGES-1:0] vld_r;
  logic              vld_q_r;
  rng_t              mem_q_r;

  assign q = vld_q_r ? mem_q_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      vld_q_r <= 1'b0;
    end else begin
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
      if (re) begin
        vld_q_r <= vld_r[raddr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      mem_q_r <= mem[raddr];
    end
  end

endmodule

### rtl/tcrr_font_mem.sv
// Font byte store, one byte per glyph row, with a registered read port.
// Depends on nothing beyond its parameters.
module tcrr_font_mem #(
  parameter int FONT_BYTES = 4096,
  parameter int FA_W       = 12
) (
  input  logic            clk,
  input  logic            we,
  input  logic [FA_W-1:0] waddr,
  input  logic [7:0]      wdata,
  input  logic            re,
  input  logic [FA_W-1:0] raddr,
  output logic [7:0]      q
);

  logic [7:0] mem [FONT_BYTES];
  logic [7:0] q_r;

  assign q = q_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      q_r <= mem[raddr];
    end
  end

endmodule

### rtl/text_cell_refresh_renderer.sv
// Top level of the text cell refresh renderer: command sequencer, range scan and row output.
// Depends on tcrr_pkg, tcrr_cfg_regs, tcrr_cell_mem, tcrr_range_mem and tcrr_font_mem.
//
//   Channel   Direction  Handshake              Beat
//   in_       input      in_valid / in_stall    one command
//   out_      output     out_valid / out_stall  one pixel row of a cell
//   cfg       input      APB psel/penable       one register write or read
//
// After reset the cell memories are swept and the sequencer moves from ST_CLEAR to ST_IDLE
// before the first command beat can be taken. Font, range and write commands stay in
// ST_IDLE; a refresh of an unchanged cell returns from ST_CMP to ST_IDLE. A drawn refresh
// goes through ST_CMP, ST_SCAN (none for codepoint zero), ST_BASE (only when the codepoint
// is found), ST_FONT and ST_EMIT; range table entries are scanned one per cycle from its
// memory, and rows leave at one per cycle unless out_stall. The last row waits in the output
// register while the next command beat is taken. Font writes at or above FONT_BYTES are
// dropped; reads wrap modulo FONT_BYTES, which the user must keep a power of two; unchecked.
module text_cell_refresh_renderer #(
  parameter int COLS       = tcrr_pkg::COLS_DEF,
  parameter int ROWS       = tcrr_pkg::ROWS_DEF,
  parameter int FONT_BYTES = tcrr_pkg::FONT_BYTES_DEF,
  parameter int RANGES     = tcrr_pkg::RANGES_DEF,
  parameter int MAX_FONT_H = tcrr_pkg::MAX_FONT_H_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  tcrr_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output tcrr_pkg::out_item_t         out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tcrr_pkg::CFG_AW-1:0] paddr,
  input  logic [tcrr_pkg::CFG_DW-1:0] pwdata,
  output logic [tcrr_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);
  import tcrr_pkg::*;

  localparam int CELLS   = COLS * ROWS;
  localparam int CELL_AW = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int FA_W    = $clog2(FONT_BYTES);
  localparam int RNG_AW  = (RANGES > 1) ? $clog2(RANGES) : 1;

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_CMP   = 7'b0000100,
    ST_SCAN  = 7'b0001000,
    ST_BASE  = 7'b0010000,
    ST_FONT  = 7'b0100000,
    ST_EMIT  = 7'b1000000
  } st_t;

  st_t st_r, st_nxt;

  cfg_t      cfg;
  cell_ctl_t cell_ctl;
  cell_t     cur_q, sh_q, cell_wd;
  logic      clr_busy;
  logic [CELL_AW-1:0] cell_addr;

  rng_t              rng_q, rng_wd;
  logic              rng_we, rng_re;
  logic [RNG_AW-1:0] rng_idx_r, rng_idx_nxt;

  logic            font_we, font_re;
  logic [FA_W-1:0] font_ra;
  logic [7:0]      font_q;

  logic        accept, in_area, out_free, out_load, is_last, hit;
  logic [4:0]  col_r;
  logic [3:0]  row_r;
  logic        force_r;
  logic        found_r, found_nxt;
  logic [15:0] delta_r, delta_nxt;
  logic [11:0] off_r, off_nxt;
  logic [21:0] base_r, base_nxt;
  logic [4:0]  line_r, line_nxt;
  logic [3:0]  w;
  logic [4:0]  h;
  logic [7:0]  wmask;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_r, out_nxt;

  tcrr_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tcrr_cell_mem #(.CELLS(CELLS), .CELL_AW(CELL_AW)) u_cells (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (cell_ctl),
    .addr  (cell_addr),
    .wdata (cell_wd),
    .cur_q (cur_q),
    .sh_q  (sh_q),
    .busy  (clr_busy)
  );

  tcrr_range_mem #(.RANGES(RANGES), .RNG_AW(RNG_AW)) u_ranges (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (rng_we),
    .waddr (RNG_AW'(in_data.range_index)),
    .wdata (rng_wd),
    .re    (rng_re),
    .raddr (rng_idx_nxt),
    .q     (rng_q)
  );

  tcrr_font_mem #(.FONT_BYTES(FONT_BYTES), .FA_W(FA_W)) u_font (
    .clk   (clk),
    .we    (font_we),
    .waddr (FA_W'(in_data.font_address)),
    .wdata (in_data.font_byte),
    .re    (font_re),
    .raddr (font_ra),
    .q     (font_q)
  );

  assign in_stall = (st_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign w = (cfg.font_width == 4'd0) ? 4'd1 :
             ((cfg.font_width > 4'd8) ? 4'd8 : cfg.font_width);
  assign h = (cfg.font_height == 5'd0) ? 5'd1 :
             ((32'(cfg.font_height) > MAX_FONT_H) ? 5'(MAX_FONT_H) : cfg.font_height);
  assign wmask = 8'((9'd1 << w) - 9'd1);

  assign in_area = ({1'b0, in_data.col} < cfg.cols_in_use) && (32'(in_data.col) < COLS) &&
                   ({1'b0, in_data.row} < cfg.rows_in_use) && (32'(in_data.row) < ROWS);

  assign cell_addr = accept ? CELL_AW'(32'(in_data.row) * COLS + 32'(in_data.col))
                            : CELL_AW'(32'(row_r) * COLS + 32'(col_r));
  assign cell_wd   = '{code: in_data.glyph, fg: in_data.fg, bg: in_data.bg};
  assign rng_wd    = '{offset: in_data.font_address, first: in_data.glyph,
                       count: in_data.range_count};

  assign hit = (rng_q.count != 16'd0) && (cur_q.code >= rng_q.first) &&
               (22'(cur_q.code) < 22'(rng_q.first) + 22'(rng_q.count));

  assign is_last  = (6'(line_r) + 6'd1) == 6'(h);
  assign out_load = (st_r == ST_EMIT) && out_free;
  assign font_ra  = FA_W'(base_r + ((st_r == ST_EMIT) ? 22'(line_r) + 22'd1 : 22'd0));

  always_comb begin
    st_nxt      = st_r;
    cell_ctl    = '0;
    rng_we      = 1'b0;
    rng_re      = 1'b0;
    rng_idx_nxt = rng_idx_r;
    font_we     = 1'b0;
    font_re     = 1'b0;
    found_nxt   = found_r;
    delta_nxt   = delta_r;
    off_nxt     = off_r;
    base_nxt    = base_r;
    line_nxt    = line_r;
    unique case (st_r)
      ST_CLEAR: begin
        if (!clr_busy) begin
          st_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_data.command)
            CMD_LOAD_FONT: begin
              font_we = 32'(in_data.font_address) < FONT_BYTES;
            end
            CMD_LOAD_RANGE: begin
              rng_we = 32'(in_data.range_index) < RANGES;
            end
            CMD_WRITE_CELL: begin
              cell_ctl.wr_cur = in_area;
            end
            default: begin
              if (in_area) begin
                cell_ctl.rd = 1'b1;
                st_nxt      = ST_CMP;
              end
            end
          endcase
        end
      end
      ST_CMP: begin
        if (force_r || (cur_q != sh_q)) begin
          cell_ctl.wr_sh = 1'b1;
          if (cur_q.code == 21'd0) begin
            found_nxt = 1'b0;
            st_nxt    = ST_FONT;
          end else begin
            rng_idx_nxt = '0;
            rng_re      = 1'b1;
            st_nxt      = ST_SCAN;
          end
        end else begin
          st_nxt = ST_IDLE;
        end
        line_nxt = '0;
      end
      ST_SCAN: begin
        if (hit) begin
          found_nxt = 1'b1;
          delta_nxt = 16'(cur_q.code - rng_q.first);
          off_nxt   = rng_q.offset;
          st_nxt    = ST_BASE;
        end else if ((rng_q.count == 16'd0) || (32'(rng_idx_r) == RANGES - 1)) begin
          found_nxt = 1'b0;
          st_nxt    = ST_FONT;
        end else begin
          rng_idx_nxt = rng_idx_r + RNG_AW'(1);
          rng_re      = 1'b1;
        end
      end
      ST_BASE: begin
        base_nxt = 22'(off_r) + 22'(delta_r) * 22'(h);
        st_nxt   = ST_FONT;
      end
      ST_FONT: begin
        font_re = 1'b1;
        st_nxt  = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          if (is_last) begin
            st_nxt = ST_IDLE;
          end else begin
            line_nxt = line_r + 5'd1;
            font_re  = 1'b1;
          end
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_nxt          = out_r;
    out_valid_nxt    = out_valid_r && out_stall;
    if (out_load) begin
      out_valid_nxt    = 1'b1;
      out_nxt.pixel_x  = 11'(cfg.x_offset) + 11'(col_r) * 11'(w);
      out_nxt.pixel_y  = 11'(cfg.y_offset) + 11'(row_r) * 11'(h) + 11'(line_r);
      out_nxt.row_bits = found_r ? (font_q & wmask) : 8'd0;
      out_nxt.fg_color = cur_q.fg;
      out_nxt.bg_color = cur_q.bg;
      out_nxt.no_glyph = !found_r;
      out_nxt.last_row = is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      col_r   <= in_data.col;
      row_r   <= in_data.row;
      force_r <= in_data.force_req;
    end
    rng_idx_r <= rng_idx_nxt;
    found_r   <= found_nxt;
    delta_r   <= delta_nxt;
    off_r     <= off_nxt;
    base_r    <= base_nxt;
    line_r    <= line_nxt;
    out_r     <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy |-> in_stall)
    else $error("command beat taken during the cell memory sweep");

  a_blank_row_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.no_glyph) |-> (out_r.row_bits == 8'd0))
    else $error("background row carries pixel bits");

  a_row_within_width: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_r.row_bits & ~wmask) == 8'd0))
    else $error("pixel bits beyond the glyph width");

  a_last_row_ends_cell: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && is_last) |=> (st_r == ST_IDLE))
    else $error("sequencer did not return to idle after the last row");

endmodule
